[rtl/cflt_pkg.sv]
// Shared constants and types for the CFL time-step limiter.
package cflt_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 24;

    // restart plus five 32-bit fields, padded to whole bytes
    localparam int S_TDATA_W = ((1 + 5 * DATA_W + 7) / 8) * 8;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR  = 1'b1;

    localparam logic [DATA_W-1:0] INITIAL_STEP_RST = 32'd167772;
    localparam logic [DATA_W-1:0] SPEED_FLOOR_RST  = 32'd1677;
    localparam logic [DATA_W-1:0] STEP_MAX         = '1;

    // convective factor 0.35 = 7 / 20, with 20 = 16 + 4
    localparam int CONV_NUM    = 7;
    localparam int CONV_STEPS  = DATA_W + 1;
    localparam int CONV_DEN_W  = DATA_W + 5;
    localparam int DEN_SHL_HI  = 4;
    localparam int DEN_SHL_LO  = 2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ABS,
        ST_MAX,
        ST_X20,
        ST_CMUL,
        ST_CCHK,
        ST_CDIV,
        ST_CFOLD,
        ST_WMUL,
        ST_HMUL,
        ST_SUM,
        ST_TMUL,
        ST_TDIV,
        ST_DMUL,
        ST_DCHK,
        ST_DDIV,
        ST_DFOLD,
        ST_DONE
    } state_t;

endpackage

[rtl/cflt_addsub.sv]
// Shared add/subtract unit with carry out (carry set means no borrow on subtract).
module cflt_addsub #(
    parameter int W = 38
) (
    input  logic [W-1:0] opa,
    input  logic [W-1:0] opb,
    input  logic         sub,
    output logic [W-1:0] sum,
    output logic         carry
);

    logic [W-1:0] opb_eff;
    logic [W:0]   total;

    assign opb_eff = sub ? ~opb : opb;
    assign total   = {1'b0, opa} + {1'b0, opb_eff} + {{W{1'b0}}, sub};
    assign sum     = total[W-1:0];
    assign carry   = total[W];

endmodule

[rtl/cfl_timestep_limiter.sv]
// CFL time-step limiter: sequencer and datapath around one shared add/subtract unit.
//
//  channel  | ports                      | contents
//  ---------+----------------------------+------------------------------------------
//  node in  | s_tvalid s_tready s_tdata  | tdata: restart, cell_width, cell_height,
//           | s_tuser                    |   face_velocity, viscosity, density
//           |                            | tuser: vertical_node
//  step out | m_tvalid m_tready m_tdata  | tdata: limited_step
//  config   | cfg_wr_en cfg_index        | index 0 initial_step, 1 speed_floor
//           | cfg_data                   |
//
// One request runs through the sequencer states from accept to m_tvalid, and the next
// request is accepted once the sequencer is back in idle; a limit that saturates early
// skips the rest of its steps. Every multiply and divide runs one bit per cycle through
// the single add/subtract unit. Reset is synchronous; no clearing pass is needed.
// The result register holds until taken and the next request is accepted meanwhile;
// a finished request waits in its last state while an earlier result is still held.
module cfl_timestep_limiter #(
    parameter int FRAC_BITS = cflt_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // restart, cell_width, cell_height, face_velocity, viscosity, density, zero pad
    input  logic [cflt_pkg::S_TDATA_W-1:0]      s_tdata,
    // vertical_node
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // limited_step
    output logic [cflt_pkg::DATA_W-1:0]         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [cflt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cflt_pkg::DATA_W-1:0]         cfg_data
);

    localparam int DW_ = cflt_pkg::DATA_W;
    localparam int SQW = 2 * DW_ - FRAC_BITS;
    localparam int DW  = (SQW + 1 > cflt_pkg::CONV_DEN_W) ? SQW + 1 : cflt_pkg::CONV_DEN_W;
    localparam int AW  = DW + 1;
    localparam int CW  = $clog2(SQW + 1);

    localparam int W_LSB   = 1;
    localparam int H_LSB   = W_LSB + DW_;
    localparam int V_LSB   = H_LSB + DW_;
    localparam int MU_LSB  = V_LSB + DW_;
    localparam int RHO_LSB = MU_LSB + DW_;

    localparam logic [SQW-1:0] CONV_MPLR = SQW'(cflt_pkg::CONV_NUM) << FRAC_BITS;

    cflt_pkg::state_t state_reg, state_next;

    logic [DW_-1:0] init_reg, floor_reg;
    logic [DW_-1:0] run_reg, run_next;
    logic           m_valid_reg, m_valid_next;
    logic [DW_-1:0] m_data_reg, m_data_next;

    logic           vert_reg;
    logic [DW_-1:0] w_reg, h_reg, v_reg, mu_reg, rho_reg;

    logic [DW-1:0]  acc_reg, acc_next;
    logic [SQW-1:0] num_reg, num_next;
    logic [DW-1:0]  dvs_reg, dvs_next;
    logic [SQW-1:0] mcand_reg, mcand_next;
    logic [SQW-1:0] a_reg, a_next;
    logic [SQW-1:0] b_reg, b_next;
    logic           sat_reg, sat_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    logic [AW-1:0]  alu_a, alu_b, alu_sum;
    logic           alu_sub, alu_carry;

    logic             accept;
    logic             last;
    logic [DW_-1:0]   size;
    logic [SQW-1:0]   mul_acc, mul_num, div_num;
    logic [AW-1:0]    mul_b, div_rs;
    logic [DW-1:0]    div_rem;
    logic [2*DW_-1:0] sq_prod;
    logic [SQW-1:0]   sq_val;
    logic [DW_-1:0]   fold_limit;

    cflt_addsub #(
        .W(AW)
    ) u_addsub (
        .opa  (alu_a),
        .opb  (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum),
        .carry(alu_carry)
    );

    assign s_tready = (state_reg == cflt_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign last    = (cnt_reg == CW'(1));
    assign size    = vert_reg ? h_reg : w_reg;
    assign mul_b   = num_reg[0] ? {{(AW - SQW){1'b0}}, mcand_reg} : '0;
    assign mul_acc = alu_sum[SQW:1];
    assign mul_num = {alu_sum[0], num_reg[SQW-1:1]};
    assign div_rs  = {acc_reg, num_reg[SQW-1]};
    assign div_rem = alu_carry ? alu_sum[DW-1:0] : div_rs[DW-1:0];
    assign div_num = {num_reg[SQW-2:0], alu_carry};
    assign sq_prod = {mul_acc[DW_-1:0], mul_num[SQW-1 -: DW_]};
    assign sq_val  = sq_prod[2*DW_-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg  <= cflt_pkg::INITIAL_STEP_RST;
            floor_reg <= cflt_pkg::SPEED_FLOOR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cflt_pkg::CFG_INITIAL_STEP: init_reg  <= cfg_data;
                cflt_pkg::CFG_SPEED_FLOOR:  floor_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            vert_reg <= s_tuser[0];
            w_reg    <= s_tdata[W_LSB +: DW_];
            h_reg    <= s_tdata[H_LSB +: DW_];
            v_reg    <= s_tdata[V_LSB +: DW_];
            mu_reg   <= s_tdata[MU_LSB +: DW_];
            rho_reg  <= s_tdata[RHO_LSB +: DW_];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cflt_pkg::ST_IDLE;
            run_reg     <= cflt_pkg::INITIAL_STEP_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        acc_reg    <= acc_next;
        num_reg    <= num_next;
        dvs_reg    <= dvs_next;
        mcand_reg  <= mcand_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        sat_reg    <= sat_next;
        cnt_reg    <= cnt_next;
    end

    // operand selection for the shared unit
    always_comb begin
        alu_a      = '0;
        alu_b      = '0;
        alu_sub    = 1'b0;
        fold_limit = (sat_reg || num_reg[DW_]) ? cflt_pkg::STEP_MAX : num_reg[DW_-1:0];
        unique case (state_reg)
            cflt_pkg::ST_ABS: begin
                alu_b   = AW'(v_reg);
                alu_sub = 1'b1;
            end
            cflt_pkg::ST_MAX: begin
                alu_a   = AW'(dvs_reg);
                alu_b   = AW'(floor_reg);
                alu_sub = 1'b1;
            end
            cflt_pkg::ST_X20: begin
                alu_a = AW'(dvs_reg) << cflt_pkg::DEN_SHL_HI;
                alu_b = AW'(dvs_reg) << cflt_pkg::DEN_SHL_LO;
            end
            cflt_pkg::ST_CMUL, cflt_pkg::ST_WMUL, cflt_pkg::ST_HMUL,
            cflt_pkg::ST_TMUL, cflt_pkg::ST_DMUL: begin
                alu_a = AW'(acc_reg);
                alu_b = mul_b;
            end
            cflt_pkg::ST_CCHK, cflt_pkg::ST_DCHK: begin
                alu_a   = AW'(acc_reg);
                alu_b   = AW'(dvs_reg);
                alu_sub = 1'b1;
            end
            cflt_pkg::ST_CDIV, cflt_pkg::ST_TDIV, cflt_pkg::ST_DDIV: begin
                alu_a   = div_rs;
                alu_b   = AW'(dvs_reg);
                alu_sub = 1'b1;
            end
            cflt_pkg::ST_SUM: begin
                alu_a = AW'(a_reg);
                alu_b = AW'(b_reg);
            end
            cflt_pkg::ST_CFOLD, cflt_pkg::ST_DFOLD: begin
                if (state_reg == cflt_pkg::ST_DFOLD) begin
                    fold_limit = sat_reg ? cflt_pkg::STEP_MAX : num_reg[DW_-1:0];
                end
                alu_a   = AW'(run_reg);
                alu_b   = AW'(fold_limit);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // sequencer and register updates
    always_comb begin
        state_next   = state_reg;
        run_next     = run_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        acc_next     = acc_reg;
        num_next     = num_reg;
        dvs_next     = dvs_reg;
        mcand_next   = mcand_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        sat_next     = sat_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            cflt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tdata[0]) begin
                        run_next = init_reg;
                    end
                    state_next = cflt_pkg::ST_ABS;
                end
            end
            cflt_pkg::ST_ABS: begin
                dvs_next   = DW'(v_reg[DW_-1] ? alu_sum[DW_-1:0] : v_reg);
                state_next = cflt_pkg::ST_MAX;
            end
            cflt_pkg::ST_MAX: begin
                if (!alu_carry) begin
                    dvs_next = DW'(floor_reg);
                end
                state_next = cflt_pkg::ST_X20;
            end
            cflt_pkg::ST_X20: begin
                dvs_next   = alu_sum[DW-1:0];
                acc_next   = '0;
                mcand_next = SQW'(size);
                num_next   = CONV_MPLR;
                cnt_next   = CW'(cflt_pkg::CONV_STEPS);
                state_next = cflt_pkg::ST_CMUL;
            end
            cflt_pkg::ST_CMUL, cflt_pkg::ST_TMUL, cflt_pkg::ST_DMUL: begin
                acc_next = DW'(mul_acc);
                num_next = mul_num;
                cnt_next = cnt_reg - CW'(1);
                if (last) begin
                    if (state_reg == cflt_pkg::ST_CMUL) begin
                        state_next = cflt_pkg::ST_CCHK;
                    end else if (state_reg == cflt_pkg::ST_TMUL) begin
                        cnt_next   = CW'(SQW);
                        state_next = cflt_pkg::ST_TDIV;
                    end else begin
                        state_next = cflt_pkg::ST_DCHK;
                    end
                end
            end
            cflt_pkg::ST_CCHK, cflt_pkg::ST_DCHK: begin
                sat_next = alu_carry;
                if (alu_carry) begin
                    state_next = (state_reg == cflt_pkg::ST_CCHK) ? cflt_pkg::ST_CFOLD
                                                                  : cflt_pkg::ST_DFOLD;
                end else if (state_reg == cflt_pkg::ST_CCHK) begin
                    cnt_next   = CW'(cflt_pkg::CONV_STEPS);
                    state_next = cflt_pkg::ST_CDIV;
                end else begin
                    cnt_next   = CW'(DW_);
                    state_next = cflt_pkg::ST_DDIV;
                end
            end
            cflt_pkg::ST_CDIV, cflt_pkg::ST_DDIV: begin
                acc_next = div_rem;
                num_next = div_num;
                cnt_next = cnt_reg - CW'(1);
                if (last) begin
                    state_next = (state_reg == cflt_pkg::ST_CDIV) ? cflt_pkg::ST_CFOLD
                                                                  : cflt_pkg::ST_DFOLD;
                end
            end
            cflt_pkg::ST_CFOLD: begin
                if (alu_carry) begin
                    run_next = fold_limit;
                end
                acc_next   = '0;
                mcand_next = SQW'(w_reg);
                num_next   = SQW'(w_reg);
                cnt_next   = CW'(DW_);
                state_next = cflt_pkg::ST_WMUL;
            end
            cflt_pkg::ST_WMUL: begin
                acc_next = DW'(mul_acc);
                num_next = mul_num;
                cnt_next = cnt_reg - CW'(1);
                if (last) begin
                    a_next     = sq_val;
                    acc_next   = '0;
                    mcand_next = SQW'(h_reg);
                    num_next   = SQW'(h_reg);
                    cnt_next   = CW'(DW_);
                    state_next = cflt_pkg::ST_HMUL;
                end
            end
            cflt_pkg::ST_HMUL: begin
                acc_next = DW'(mul_acc);
                num_next = mul_num;
                cnt_next = cnt_reg - CW'(1);
                if (last) begin
                    b_next     = sq_val;
                    state_next = cflt_pkg::ST_SUM;
                end
            end
            cflt_pkg::ST_SUM: begin
                dvs_next = alu_sum[DW-1:0];
                sat_next = (alu_sum == '0);
                if (alu_sum == '0) begin
                    state_next = cflt_pkg::ST_DFOLD;
                end else begin
                    acc_next   = '0;
                    mcand_next = a_reg;
                    num_next   = b_reg;
                    cnt_next   = CW'(SQW);
                    state_next = cflt_pkg::ST_TMUL;
                end
            end
            cflt_pkg::ST_TDIV: begin
                acc_next = div_rem;
                num_next = div_num;
                cnt_next = cnt_reg - CW'(1);
                if (last) begin
                    mcand_next = div_num;
                    num_next   = SQW'(rho_reg);
                    acc_next   = '0;
                    dvs_next   = {{(DW - DW_ - 1){1'b0}}, mu_reg, 1'b0};
                    cnt_next   = CW'(DW_);
                    state_next = cflt_pkg::ST_DMUL;
                end
            end
            cflt_pkg::ST_DFOLD: begin
                if (alu_carry) begin
                    run_next = fold_limit;
                end
                state_next = cflt_pkg::ST_DONE;
            end
            cflt_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = run_reg;
                    state_next   = cflt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cflt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[test/tb_top.sv]
// Self-checking testbench for the CFL time-step limiter: directed and random nodes.
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC       = cflt_pkg::FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic        restart;
        logic        vertical;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] velocity;
        logic [31:0] viscosity;
        logic [31:0] density;
    } node_t;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [cflt_pkg::S_TDATA_W-1:0]       s_tdata   = '0;
    logic [0:0]                           s_tuser   = '0;
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [cflt_pkg::DATA_W-1:0]          m_tdata;
    logic                                 cfg_wr_en = 1'b0;
    logic [cflt_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [cflt_pkg::DATA_W-1:0]          cfg_data  = '0;

    node_t       node_q[$];
    logic [31:0] expected_steps[$];
    node_t       cur_node;
    logic        item_busy  = 1'b0;
    logic        s_fire     = 1'b0;
    int          gap_left   = 0;
    int          stall_left = 0;
    logic        calm       = 1'b0;
    int          errors     = 0;
    int          idle_cycles = 0;
    logic [31:0] want;

    logic [31:0] init_shadow  = cflt_pkg::INITIAL_STEP_RST;
    logic [31:0] floor_shadow = cflt_pkg::SPEED_FLOOR_RST;
    logic [31:0] run_step     = cflt_pkg::INITIAL_STEP_RST;

    cfl_timestep_limiter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [31:0] sat_quot(logic [127:0] num, logic [127:0] dvs);
        logic [127:0] q;
        if (dvs == 0) return '1;
        q = num / dvs;
        return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic [31:0] advance_step(node_t n);
        logic [31:0]  mag;
        logic [127:0] size, den, a, b, t;
        logic [31:0]  conv, diff;
        if (n.restart) run_step = init_shadow;
        size = 128'(n.vertical ? n.height : n.width);
        mag  = n.velocity[31] ? (~n.velocity + 32'd1) : n.velocity;
        den  = 128'((mag > floor_shadow) ? mag : floor_shadow);
        conv = sat_quot((size * 7) << FRAC, den * 20);
        a = (128'(n.width) * n.width) >> FRAC;
        b = (128'(n.height) * n.height) >> FRAC;
        if (a + b == 0) begin
            diff = '1;
        end else begin
            t    = (a * b) / (a + b);
            diff = sat_quot(128'(n.density) * t, 128'(n.viscosity) * 2);
        end
        if (conv < run_step) run_step = conv;
        if (diff < run_step) run_step = diff;
        return run_step;
    endfunction

    function automatic node_t make_node(logic r, logic vert, logic [31:0] w, logic [31:0] h,
                                        logic [31:0] v, logic [31:0] mu, logic [31:0] rho);
        node_t n;
        n.restart   = r;
        n.vertical  = vert;
        n.width     = w;
        n.height    = h;
        n.velocity  = v;
        n.viscosity = mu;
        n.density   = rho;
        return n;
    endfunction

    function automatic logic [31:0] corner_val();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic node_t rand_node();
        node_t       n;
        int unsigned pick;
        logic [31:0] mag;
        pick       = $urandom_range(0, 99);
        n.restart  = ($urandom_range(0, 7) == 0);
        n.vertical = ($urandom_range(0, 1) == 1);
        if (pick < 15) begin
            n.width     = $urandom;
            n.height    = $urandom;
            n.velocity  = $urandom;
            n.viscosity = $urandom;
            n.density   = $urandom;
        end else if (pick < 22) begin
            n.width     = corner_val();
            n.height    = corner_val();
            n.velocity  = corner_val();
            n.viscosity = corner_val();
            n.density   = corner_val();
        end else begin
            n.width     = $urandom_range(32'h0000_1000, 32'h0200_0000);
            n.height    = $urandom_range(32'h0000_1000, 32'h0200_0000);
            mag         = $urandom >> $urandom_range(4, 31);
            n.velocity  = ($urandom_range(0, 1) == 1) ? -mag : mag;
            n.viscosity = $urandom >> $urandom_range(2, 31);
            n.density   = $urandom >> $urandom_range(2, 31);
        end
        return n;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, exp_val, got, $realtime);
        errors++;
    endtask

    task automatic write_reg(logic [cflt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == cflt_pkg::CFG_INITIAL_STEP) init_shadow = value;
        else if (idx == cflt_pkg::CFG_SPEED_FLOOR) floor_shadow = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (node_q.size() != 0 || item_busy || expected_steps.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // driver: present queued nodes with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_fire) begin
                item_busy = 1'b0;
                s_fire    = 1'b0;
            end
            if (!item_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (node_q.size() != 0) begin
                    cur_node  = node_q.pop_front();
                    item_busy = 1'b1;
                    s_tdata   <= {{(cflt_pkg::S_TDATA_W - 161){1'b0}}, cur_node.density,
                                  cur_node.viscosity, cur_node.velocity, cur_node.height,
                                  cur_node.width, cur_node.restart};
                    s_tuser   <= cur_node.vertical;
                    gap_left  = pick_gap();
                end
            end
            s_tvalid <= item_busy;
        end
    end

    // result side stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: check results, then predict for the accepted request
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_steps.size() == 0) begin
                    report_mismatch("unexpected result", '0, m_tdata);
                end else begin
                    want = expected_steps.pop_front();
                    if (m_tdata !== want) report_mismatch("limited_step", want, m_tdata);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_steps.push_back(advance_step(cur_node));
                s_fire = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[cfl_timestep_limiter] ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] w0, h0, v0, mu0, rho0;
        int          ph;
        w0   = 32'd167772;
        h0   = 32'd335544;
        v0   = 32'h0100_0000;
        mu0  = 32'd16777;
        rho0 = 32'h0100_0000;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        node_q.push_back(make_node(1'b1, 1'b0, w0, h0, v0, mu0, rho0));
        node_q.push_back(make_node(1'b0, 1'b1, w0, h0, 32'hFE00_0000, mu0, rho0));
        node_q.push_back(make_node(1'b1, 1'b0, w0, h0, 32'h8000_0000, mu0, rho0));
        node_q.push_back(make_node(1'b1, 1'b1, w0, h0, 32'h7FFF_FFFF, mu0, rho0));
        node_q.push_back(make_node(1'b1, 1'b0, w0, h0, 32'h0, mu0, rho0));
        node_q.push_back(make_node(1'b1, 1'b0, w0, h0, v0, 32'h0, rho0));
        node_q.push_back(make_node(1'b1, 1'b1, w0, h0, v0, mu0, 32'h0));
        node_q.push_back(make_node(1'b0, 1'b0, w0, h0, v0, mu0, rho0));
        node_q.push_back(make_node(1'b1, 1'b0, 32'hFFF, 32'hFFF, v0, mu0, rho0));
        node_q.push_back(make_node(1'b1, 1'b1, '0, '0, '0, '0, '0));
        node_q.push_back(make_node(1'b1, 1'b0, '1, '1, 32'h1, 32'h1, '1));
        node_q.push_back(make_node(1'b1, 1'b1, '1, '1, '1, '1, '1));
        node_q.push_back(make_node(1'b0, 1'b0, 32'h1, '1, 32'h7FFF_FFFF, 32'h1, '1));
        wait_drained();

        write_reg(cflt_pkg::CFG_INITIAL_STEP, '1);
        write_reg(cflt_pkg::CFG_SPEED_FLOOR, '0);
        node_q.push_back(make_node(1'b1, 1'b0, w0, h0, 32'h0, mu0, rho0));
        node_q.push_back(make_node(1'b1, 1'b1, '1, '1, '0, '0, '1));
        node_q.push_back(make_node(1'b0, 1'b0, '1, '1, '0, 32'h1, '1));
        node_q.push_back(make_node(1'b1, 1'b1, '0, '0, '0, '0, '0));
        node_q.push_back(make_node(1'b1, 1'b0, w0, h0, 32'h8000_0000, mu0, rho0));
        node_q.push_back(make_node(1'b0, 1'b1, w0, h0, 32'h1, mu0, rho0));
        node_q.push_back(make_node(1'b1, 1'b0, 32'h1, 32'h1, '1, '1, '0));
        wait_drained();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(cflt_pkg::CFG_INITIAL_STEP, '0);
                    write_reg(cflt_pkg::CFG_SPEED_FLOOR, '1);
                end
                1: begin
                    write_reg(cflt_pkg::CFG_INITIAL_STEP, $urandom);
                    write_reg(cflt_pkg::CFG_SPEED_FLOOR, $urandom >> $urandom_range(8, 31));
                end
                2: begin
                    write_reg(cflt_pkg::CFG_INITIAL_STEP, cflt_pkg::INITIAL_STEP_RST);
                    write_reg(cflt_pkg::CFG_SPEED_FLOOR, cflt_pkg::SPEED_FLOOR_RST);
                end
                3: begin
                    write_reg(cflt_pkg::CFG_INITIAL_STEP, $urandom);
                    write_reg(cflt_pkg::CFG_SPEED_FLOOR, $urandom);
                end
                default: begin
                    write_reg(cflt_pkg::CFG_INITIAL_STEP, '1);
                    write_reg(cflt_pkg::CFG_SPEED_FLOOR, '0);
                end
            endcase
            calm = (ph == 2) || ($urandom_range(0, 3) == 0);
            repeat (100) node_q.push_back(rand_node());
            wait_drained();
            calm = 1'b0;
        end

        repeat (300) @(posedge aclk);
        if (expected_steps.size() != 0)
            report_mismatch("missing result", expected_steps[0], '0);
        if (errors == 0) begin
            $display("[cfl_timestep_limiter] OK");
        end else begin
            $display("[cfl_timestep_limiter] ERROR");
        end
        $finish;
    end

endmodule
